// ----- hw/rtl/mcpwm_pkg.sv -----
package mcpwm_pkg;

    // Field widths of the item ports
    localparam int KIND_W     = 2;
    localparam int CHAN_W     = 4;
    localparam int COUNT_IN_W = 16;
    localparam int PINS_W     = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Channel phase codes
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_IDLE = 2'd2;

    // Command broadcast to every channel cell, one per item
    typedef struct packed {
        logic              tick;
        logic              set;
        logic              clear;
        logic [CHAN_W-1:0] channel;
    } cmd_t;

    // Status returned by each channel cell
    typedef struct packed {
        logic pin_next;
        logic idle_next;
        logic idle;
    } chan_stat_t;

endpackage

// ----- hw/rtl/mcpwm_channel.sv -----
module mcpwm_channel #(
    parameter int IDX        = 0,
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mcpwm_pkg::cmd_t       cmd,
    input  logic [COUNT_BITS-1:0] low_cnt,
    input  logic [COUNT_BITS-1:0] high_cnt,
    output mcpwm_pkg::chan_stat_t stat
);

    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] low_len_reg, low_len_next;
    logic [COUNT_BITS-1:0] high_len_reg, high_len_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  pin_reg, pin_next;
    logic                  sel;

    assign sel = cmd.set && (cmd.channel == mcpwm_pkg::CHAN_W'(IDX));

    always_comb begin
        cnt_next      = cnt_reg;
        low_len_next  = low_len_reg;
        high_len_next = high_len_reg;
        phase_next    = phase_reg;
        pin_next      = pin_reg;
        if (cmd.clear) begin
            // drop to idle, keep the pin level
            cnt_next      = '0;
            low_len_next  = '0;
            high_len_next = '0;
            phase_next    = mcpwm_pkg::PH_IDLE;
        end else if (sel) begin
            cnt_next      = high_cnt;
            low_len_next  = low_cnt;
            high_len_next = high_cnt;
            if (high_cnt == '0) begin
                pin_next   = 1'b0;
                phase_next = mcpwm_pkg::PH_IDLE;
            end else begin
                pin_next   = 1'b1;
                phase_next = (low_cnt == '0) ? mcpwm_pkg::PH_IDLE : mcpwm_pkg::PH_HIGH;
            end
        end else if (cmd.tick && (phase_reg == mcpwm_pkg::PH_LOW ||
                                  phase_reg == mcpwm_pkg::PH_HIGH)) begin
            if (cnt_reg == '0) begin
                if (phase_reg == mcpwm_pkg::PH_HIGH) begin
                    phase_next = mcpwm_pkg::PH_LOW;
                    cnt_next   = low_len_reg;
                    pin_next   = 1'b0;
                end else begin
                    phase_next = mcpwm_pkg::PH_HIGH;
                    cnt_next   = high_len_reg;
                    pin_next   = 1'b1;
                end
            end else begin
                cnt_next = cnt_reg - COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            low_len_reg  <= '0;
            high_len_reg <= '0;
            phase_reg    <= mcpwm_pkg::PH_IDLE;
            pin_reg      <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            low_len_reg  <= low_len_next;
            high_len_reg <= high_len_next;
            phase_reg    <= phase_next;
            pin_reg      <= pin_next;
        end
    end

    assign stat.pin_next  = pin_next;
    assign stat.idle_next = !(phase_next == mcpwm_pkg::PH_LOW ||
                              phase_next == mcpwm_pkg::PH_HIGH);
    assign stat.idle      = !(phase_reg == mcpwm_pkg::PH_LOW ||
                              phase_reg == mcpwm_pkg::PH_HIGH);

endmodule

// ----- hw/rtl/multichannel_soft_pwm.sv -----
// Bank of software PWM channels driven by a stream of items.
// Input channel (s_valid/s_ready): one item carries s_kind (tick, set one
// channel, clear all), s_channel and the two phase counts. Every accepted
// item yields exactly one result item on the m_valid/m_ready channel: the
// pin levels of all channels after that item, bit n for channel n, with
// bits at or above CHANNELS held at zero.
// An accepted item passes through the input register and then the result
// register before it is presented on m_pins. Throughput: one item per
// cycle; every channel cell updates in parallel, so the input register
// drains whenever the result register is free or being taken.
// Stall: while m_ready is low the result holds and the input register
// keeps its item; s_ready falls only once both stages are full.
// Reset (aresetn low, synchronous): every channel idle, counters and
// lengths zero, pins low, both stages empty.
module multichannel_soft_pwm #(
    parameter int CHANNELS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mcpwm_pkg::KIND_W-1:0]          s_kind,
    input  logic [mcpwm_pkg::CHAN_W-1:0]          s_channel,
    input  logic [mcpwm_pkg::COUNT_IN_W-1:0]      s_low_count,
    input  logic [mcpwm_pkg::COUNT_IN_W-1:0]      s_high_count,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mcpwm_pkg::PINS_W-1:0]          m_pins
);

    // Input register
    logic                                 in_valid_reg;
    logic [mcpwm_pkg::KIND_W-1:0]         kind_reg;
    logic [mcpwm_pkg::CHAN_W-1:0]         chan_reg;
    logic [mcpwm_pkg::COUNT_IN_W-1:0]     low_reg;
    logic [mcpwm_pkg::COUNT_IN_W-1:0]     high_reg;

    // Result register
    logic                                 out_valid_reg;
    logic [mcpwm_pkg::PINS_W-1:0]         pins_reg, pins_next;

    logic                                 adv;
    logic                                 load_in;
    mcpwm_pkg::cmd_t                      cmd;
    logic [31:0]                          low_wide, high_wide;
    logic [COUNT_BITS-1:0]                low_cnt, high_cnt;
    mcpwm_pkg::chan_stat_t                stat [CHANNELS];
    logic [CHANNELS-1:0]                  pin_vec;
    logic [CHANNELS-1:0]                  idle_vec;
    logic [CHANNELS-1:0]                  idle_next_vec;

    // Advance the held item into the result register when that is free or
    // being taken this cycle.
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign load_in = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load_in) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            kind_reg <= s_kind;
            chan_reg <= s_channel;
            low_reg  <= s_low_count;
            high_reg <= s_high_count;
        end
    end

    // Cut or widen the counts to the counter width.
    assign low_wide  = 32'(low_reg);
    assign high_wide = 32'(high_reg);
    assign low_cnt   = low_wide[COUNT_BITS-1:0];
    assign high_cnt  = high_wide[COUNT_BITS-1:0];

    // Decode the item; an unknown kind moves nothing but still reports pins.
    assign cmd.tick    = adv && (kind_reg == mcpwm_pkg::KIND_TICK);
    assign cmd.set     = adv && (kind_reg == mcpwm_pkg::KIND_SET);
    assign cmd.clear   = adv && (kind_reg == mcpwm_pkg::KIND_CLEAR);
    assign cmd.channel = chan_reg;

    // One cell per channel; a set for a channel with no cell matches none.
    for (genvar n = 0; n < CHANNELS; n++) begin : g_chan
        mcpwm_channel #(
            .IDX        (n),
            .COUNT_BITS (COUNT_BITS)
        ) u_chan (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .low_cnt  (low_cnt),
            .high_cnt (high_cnt),
            .stat     (stat[n])
        );
        assign pin_vec[n]       = stat[n].pin_next;
        assign idle_vec[n]      = stat[n].idle;
        assign idle_next_vec[n] = stat[n].idle_next;
    end

    assign pins_next = mcpwm_pkg::PINS_W'(pin_vec);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pins_reg <= pins_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pins  = pins_reg;

    // A processed item always lands in the result register.
    a_adv_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    // Backpressure only when the input register is holding an item.
    a_ready_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("s_ready low without a full pipeline");

    // A held item that cannot advance stays in the input register.
    a_hold_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(kind_reg)))
        else $error("held item lost from the input register");

    // After a clear every channel is idle.
    a_clear_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (idle_vec == {CHANNELS{1'b1}}))
        else $error("channel active after clear all");

    // Pins of channels that do not exist stay low.
    a_unused_pins_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pins >> CHANNELS) == '0))
        else $error("pin set above the channel count");

    // Channels never leave idle on a tick.
    a_tick_no_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick |-> ((idle_vec & ~idle_next_vec) == '0))
        else $error("idle channel woken by a tick");

endmodule
